FILE: rtl/npdt_pkg.sv
// shared constants for the nearest point dock table
package npdt_pkg;

  // default sizes
  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned COORD_BITS_DEF = 24;

  // fixed field widths
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned RANGE_W   = 24;
  localparam int unsigned TGT_W     = 7;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned IDX_OUT_W = 6;
  localparam int unsigned CNT_OUT_W = 7;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_NEAREST = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DOCK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CYCLE   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd6;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

FILE: rtl/nearest_point_dock_table_top.sv
// top level of the nearest point dock table
// A table of up to MAX_POINTS 3D points (signed COORD_BITS-bit coordinates plus a dockable
// flag) with an active target index. One transaction in gives exactly one result transaction
// out. Clear, append, set target, cycle and read load the result register at the first edge
// after acceptance, and the next transaction can be accepted one cycle later. Nearest and dock
// queries scan the stored points through a single read port of the point memory, one point per
// cycle, into a 3-stage squared distance pipeline: the result register is loaded from the done
// state once every read is issued and the read register and the pipeline have drained, and the
// next transaction can be accepted after that. A stalled output holds off the result. A new
// transaction is accepted while the previous result still waits on the output register; the
// block works on one transaction at a time. Squared distances are exact (2*COORD_BITS+2 bits);
// the nearest query keeps the lowest index on a tie and the dock query reports the lowest-index
// dockable point strictly inside dock_range. Table entries are not cleared at reset: a clear
// only zeroes the point count and drops the target index.
module nearest_point_dock_table_top
  #(
  parameter int unsigned MAX_POINTS = npdt_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = npdt_pkg::COORD_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [npdt_pkg::CMD_W-1:0]         cmd_i,
  input  logic signed [COORD_BITS-1:0]       coord_x_i,
  input  logic signed [COORD_BITS-1:0]       coord_y_i,
  input  logic signed [COORD_BITS-1:0]       coord_z_i,
  input  logic                               dockable_i,
  input  logic [npdt_pkg::RANGE_W-1:0]       dock_range_i,
  input  logic signed [npdt_pkg::TGT_W-1:0]  target_index_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [npdt_pkg::STATUS_W-1:0]      status_o,
  output logic                               hit_o,
  output logic [npdt_pkg::IDX_OUT_W-1:0]     hit_index_o,
  output logic                               target_valid_o,
  output logic [npdt_pkg::IDX_OUT_W-1:0]     target_now_o,
  output logic [npdt_pkg::CNT_OUT_W-1:0]     count_now_o
);

  import npdt_pkg::*;

  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned MEM_W = 3 * COORD_BITS + 1;
  localparam int unsigned D_W   = 2 * COORD_BITS + 2;
  localparam int unsigned RSQ_W = 2 * RANGE_W;
  localparam int unsigned CMP_W = (D_W > RSQ_W) ? D_W : RSQ_W;
  localparam int unsigned TC_W  = (CNT_W > TGT_W) ? CNT_W : TGT_W;

  // controller states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  // captured transaction
  logic [CMD_W-1:0]            cmd_q;
  logic signed [COORD_BITS-1:0] qx_q, qy_q, qz_q;
  logic                        dock_q;
  logic [RANGE_W-1:0]          range_q;
  logic [TGT_W-1:0]            tgt_q;
  logic [RSQ_W-1:0]            rsq_q;

  // table bookkeeping
  logic [CNT_W-1:0] total_q, total_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic             set_q, set_d;
  logic [STATUS_W-1:0] st_d;

  // scan state
  logic [CNT_W-1:0] issue_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             hit_q;
  logic [IDX_W-1:0] hidx_q;
  logic [D_W-1:0]   best_q;

  // result register
  logic                 out_vld_q;
  logic [STATUS_W-1:0]  status_q;
  logic                 hit_res_q;
  logic [IDX_OUT_W-1:0] hidx_res_q;
  logic                 tv_q;
  logic [IDX_OUT_W-1:0] tnow_q;
  logic [CNT_OUT_W-1:0] cnt_q;

  logic is_query, full, out_free, exec_commit, done_commit, commit;
  logic rd_en, scan_end, mem_we;
  logic [MEM_W-1:0] rdata;
  logic [CNT_W-1:0] slot_inc;

  // distance pipeline outputs
  logic             p_vld, p_dock, p_busy;
  logic [IDX_W-1:0] p_idx;
  logic [D_W-1:0]   p_dist;

  assign is_query    = (cmd_q == CMD_NEAREST) || (cmd_q == CMD_DOCK);
  assign full        = (total_q == CNT_W'(MAX_POINTS));
  assign out_free    = !out_vld_q || out_ready_i;
  assign exec_commit = (state_q == S_EXEC) && !is_query && out_free;
  assign done_commit = (state_q == S_DONE) && out_free;
  assign commit      = exec_commit || done_commit;
  assign in_ready_o  = (state_q == S_IDLE);

  // scan issues one read per cycle, then waits for the pipeline to drain
  assign rd_en    = (state_q == S_SCAN) && (issue_q != total_q);
  assign scan_end = (state_q == S_SCAN) && !rd_en && !rd_vld_q && !p_busy;
  assign mem_we   = exec_commit && (cmd_q == CMD_APPEND) && !full;
  assign slot_inc = CNT_W'(slot_q) + CNT_W'(1);

  // next table state for non-query commands
  always_comb begin
    total_d = total_q;
    slot_d  = slot_q;
    set_d   = set_q;
    st_d    = ST_OK;
    case (cmd_q)
      CMD_CLEAR: begin
        total_d = '0;
        slot_d  = '0;
        set_d   = 1'b0;
      end
      CMD_APPEND: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          if (total_q == '0) begin
            slot_d = '0;
            set_d  = 1'b1;
          end
          total_d = total_q + CNT_W'(1);
        end
      end
      CMD_SET: begin
        if (tgt_q == '1) begin
          set_d  = 1'b0;
          slot_d = '0;
        end else if (!tgt_q[TGT_W-1] &&
                     (TC_W'(tgt_q[TGT_W-2:0]) < TC_W'(total_q))) begin
          set_d  = 1'b1;
          slot_d = IDX_W'(tgt_q[TGT_W-2:0]);
        end else begin
          st_d = ST_RANGE;
        end
      end
      CMD_CYCLE: begin
        if (total_q != '0) begin
          if (!set_q || (slot_inc == total_q)) begin
            slot_d = '0;
          end else begin
            slot_d = slot_inc[IDX_W-1:0];
          end
          set_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        if (is_query) state_d = S_SCAN;
        else if (out_free) state_d = S_IDLE;
      end
      S_SCAN: if (scan_end) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      total_q   <= '0;
      slot_q    <= '0;
      set_q     <= 1'b0;
      issue_q   <= '0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (exec_commit) begin
        total_q <= total_d;
        slot_q  <= slot_d;
        set_q   <= set_d;
      end
      // start of a query scan
      if ((state_q == S_EXEC) && is_query) begin
        issue_q <= '0;
        hit_q   <= 1'b0;
      end else begin
        if (rd_en) issue_q <= issue_q + CNT_W'(1);
        if (p_vld) begin
          if (cmd_q == CMD_NEAREST) begin
            if (!hit_q || (p_dist < best_q)) hit_q <= 1'b1;
          end else if (!hit_q && p_dock &&
                       (CMP_W'(p_dist) < CMP_W'(rsq_q))) begin
            hit_q <= 1'b1;
          end
        end
      end
      if (commit) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  // transaction capture, range square, best distance and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= cmd_i;
      qx_q    <= coord_x_i;
      qy_q    <= coord_y_i;
      qz_q    <= coord_z_i;
      dock_q  <= dockable_i;
      range_q <= dock_range_i;
      tgt_q   <= target_index_i;
    end
    if (state_q == S_EXEC) begin
      rsq_q  <= range_q * range_q;
      hidx_q <= '0;
    end else if (p_vld) begin
      if (cmd_q == CMD_NEAREST) begin
        if (!hit_q || (p_dist < best_q)) begin
          best_q <= p_dist;
          hidx_q <= p_idx;
        end
      end else if (!hit_q && p_dock && (CMP_W'(p_dist) < CMP_W'(rsq_q))) begin
        hidx_q <= p_idx;
      end
    end
    if (rd_en) rd_idx_q <= issue_q[IDX_W-1:0];
    if (exec_commit) begin
      status_q   <= st_d;
      hit_res_q  <= 1'b0;
      hidx_res_q <= '0;
      tv_q       <= set_d;
      tnow_q     <= set_d ? IDX_OUT_W'(slot_d) : '0;
      cnt_q      <= CNT_OUT_W'(total_d);
    end else if (done_commit) begin
      status_q   <= ST_OK;
      hit_res_q  <= hit_q;
      hidx_res_q <= hit_q ? IDX_OUT_W'(hidx_q) : '0;
      tv_q       <= set_q;
      tnow_q     <= set_q ? IDX_OUT_W'(slot_q) : '0;
      cnt_q      <= CNT_OUT_W'(total_q);
    end
  end

  // point storage, entry layout {dock, x, y, z}
  npdt_point_mem #(
    .DEPTH  (MAX_POINTS),
    .WIDTH  (MEM_W),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (total_q[IDX_W-1:0]),
    .wdata_i ({dock_q, qx_q, qy_q, qz_q}),
    .re_i    (rd_en),
    .raddr_i (issue_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  npdt_dist_pipe #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rd_vld_q),
    .idx_i  (rd_idx_q),
    .dock_i (rdata[MEM_W-1]),
    .px_i   (rdata[3*COORD_BITS-1:2*COORD_BITS]),
    .py_i   (rdata[2*COORD_BITS-1:COORD_BITS]),
    .pz_i   (rdata[COORD_BITS-1:0]),
    .qx_i   (qx_q),
    .qy_i   (qy_q),
    .qz_i   (qz_q),
    .vld_o  (p_vld),
    .idx_o  (p_idx),
    .dock_o (p_dock),
    .dist_o (p_dist),
    .busy_o (p_busy)
  );

  assign out_valid_o    = out_vld_q;
  assign status_o       = status_q;
  assign hit_o          = hit_res_q;
  assign hit_index_o    = hidx_res_q;
  assign target_valid_o = tv_q;
  assign target_now_o   = tnow_q;
  assign count_now_o    = cnt_q;

endmodule

FILE: rtl/npdt_point_mem.sv
// point table storage: one write port, one registered read port
module npdt_point_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 73,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/npdt_dist_pipe.sv
// three-stage squared distance pipeline: abs diff, square, sum
module npdt_dist_pipe #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned IDX_W      = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          vld_i,
  input  logic [IDX_W-1:0]              idx_i,
  input  logic                          dock_i,
  input  logic signed [COORD_BITS-1:0]  px_i,
  input  logic signed [COORD_BITS-1:0]  py_i,
  input  logic signed [COORD_BITS-1:0]  pz_i,
  input  logic signed [COORD_BITS-1:0]  qx_i,
  input  logic signed [COORD_BITS-1:0]  qy_i,
  input  logic signed [COORD_BITS-1:0]  qz_i,
  output logic                          vld_o,
  output logic [IDX_W-1:0]              idx_o,
  output logic                          dock_o,
  output logic [2*COORD_BITS+1:0]       dist_o,
  output logic                          busy_o
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned D_W = 2 * C + 2;

  logic signed [C:0] dx, dy, dz;
  logic [C:0]        nx, ny, nz;
  logic [C-1:0]      mx, my, mz;

  logic [C-1:0]   mx_q, my_q, mz_q;
  logic [2*C-1:0] sx_q, sy_q, sz_q;
  logic [D_W-1:0] dist_q;
  logic [2:0]     vld_q;
  logic [IDX_W-1:0] idx1_q, idx2_q, idx3_q;
  logic [2:0]     dock_q;

  // magnitude of a difference of two C-bit values fits in C bits
  always_comb begin
    dx = $signed({px_i[C-1], px_i}) - $signed({qx_i[C-1], qx_i});
    dy = $signed({py_i[C-1], py_i}) - $signed({qy_i[C-1], qy_i});
    dz = $signed({pz_i[C-1], pz_i}) - $signed({qz_i[C-1], qz_i});
    nx = -dx;
    ny = -dy;
    nz = -dz;
    mx = dx[C] ? nx[C-1:0] : dx[C-1:0];
    my = dy[C] ? ny[C-1:0] : dy[C-1:0];
    mz = dz[C] ? nz[C-1:0] : dz[C-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q   <= mx;
    my_q   <= my;
    mz_q   <= mz;
    sx_q   <= mx_q * mx_q;
    sy_q   <= my_q * my_q;
    sz_q   <= mz_q * mz_q;
    dist_q <= {2'b00, sx_q} + {2'b00, sy_q} + {2'b00, sz_q};
    idx1_q <= idx_i;
    idx2_q <= idx1_q;
    idx3_q <= idx2_q;
    dock_q <= {dock_q[1:0], dock_i};
  end

  assign vld_o  = vld_q[2];
  assign idx_o  = idx3_q;
  assign dock_o = dock_q[2];
  assign dist_o = dist_q;
  assign busy_o = |vld_q;

endmodule
